// ----- src/prp_pkg.sv -----
`default_nettype none
package prp_pkg;

   localparam int MAX_PIECES      = 1024;
   localparam int AVAIL_WORD_BITS = 32;
   localparam int COUNT_BITS      = 16;
   localparam int PIECE_BITS      = 10;
   localparam int NUM_WORDS       = 32;
   localparam int WORD_IDX_BITS   = 5;
   localparam int BIT_IDX_BITS    = 5;
   localparam int NUM_BITS        = 11;
   localparam int CMD_BITS        = 4;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
   localparam logic [NUM_BITS-1:0]   PIECES_LIMIT = NUM_BITS'(MAX_PIECES);

   typedef enum logic [CMD_BITS-1:0] {
      CMD_LOAD      = 4'd0,
      CMD_ADD       = 4'd1,
      CMD_REMOVE    = 4'd2,
      CMD_INC       = 4'd3,
      CMD_DEC       = 4'd4,
      CMD_RESERVE   = 4'd5,
      CMD_UNRESERVE = 4'd6,
      CMD_GOT       = 4'd7,
      CMD_LOST      = 4'd8,
      CMD_PICK      = 4'd9,
      CMD_INTEREST  = 4'd10,
      CMD_QUERY     = 4'd11,
      CMD_NOP       = 4'd12
   } cmd_type;

   typedef struct packed {
      logic                  have;
      logic                  rsv;
      logic [COUNT_BITS-1:0] cnt;
   } entry_type;

   typedef struct packed {
      cmd_type                    op;
      logic                       ok;
      logic [PIECE_BITS-1:0]      piece;
      logic [WORD_IDX_BITS-1:0]   widx;
      logic [AVAIL_WORD_BITS-1:0] wdata;
   } job_type;

   typedef struct packed {
      logic                  valid;
      logic                  found;
      logic [PIECE_BITS-1:0] picked;
      logic [COUNT_BITS-1:0] count;
      logic                  held;
   } rsp_type;

endpackage
`default_nettype wire

// ----- src/rarest_first_piece_picker.sv -----
`default_nettype none
// Rarest-first piece picker. A command is taken when start is high and busy
// is low; every command gives exactly one result, shown for one cycle with
// rsp_valid high, and the receiver cannot stall it. After reset the block
// sweeps its 1024-entry piece memory to zero with busy high. A front stage
// decodes commands into a two-entry queue, a back stage runs them against
// the piece memory (one read and one write port). Load and unused commands
// answer from idle, single-piece ones after an entry read; add, remove,
// pick and interested walk every tracked piece, one memory read a cycle.
// The busy output rises when the queue is full. Configuration is written
// through csr_write_enable, csr_index (0 pick_mode, 1 pieces_in_use) and
// csr_write_data by the user while the block is idle; the block does not enforce it.
module rarest_first_piece_picker (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  start,
   output logic                                       busy,
   input  wire logic [prp_pkg::CMD_BITS-1:0]          req_cmd,
   input  wire logic [prp_pkg::PIECE_BITS-1:0]        req_piece_id,
   input  wire logic [prp_pkg::WORD_IDX_BITS-1:0]     req_word_index,
   input  wire logic [prp_pkg::AVAIL_WORD_BITS-1:0]   req_word_data,
   output logic                                       rsp_valid,
   output logic                                       rsp_found,
   output logic [prp_pkg::PIECE_BITS-1:0]             rsp_picked_piece,
   output logic [prp_pkg::COUNT_BITS-1:0]             rsp_peer_count,
   output logic                                       rsp_held,
   input  wire logic                                  csr_write_enable,
   input  wire logic                                  csr_index,
   input  wire logic [prp_pkg::NUM_BITS-1:0]          csr_write_data
);
   import prp_pkg::*;

   localparam logic CSR_PICK_MODE = 1'b0;

   // configuration registers
   logic                pick_mode_ff;
   logic [NUM_BITS-1:0] pieces_ff;
   logic [NUM_BITS-1:0] active_pieces;

   logic    clearing, job_valid, pop;
   job_type job;
   rsp_type rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         pick_mode_ff <= 1'b1;
         pieces_ff    <= PIECES_LIMIT;
      end else if (csr_write_enable) begin
         if (csr_index == CSR_PICK_MODE) pick_mode_ff <= csr_write_data[0];
         else pieces_ff <= csr_write_data;
      end
   end

   // counts above the memory depth act as the full depth
   assign active_pieces = (pieces_ff > PIECES_LIMIT) ? PIECES_LIMIT : pieces_ff;

   // front: decode and queue
   prp_front u_front (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .hold          (clearing),
      .cmd           (req_cmd),
      .piece_id      (req_piece_id),
      .word_index    (req_word_index),
      .word_data     (req_word_data),
      .active_pieces (active_pieces),
      .pop           (pop),
      .busy          (busy),
      .job_valid     (job_valid),
      .job           (job)
   );

   // back: piece memory, scans and updates
   prp_back u_back (
      .clock         (clock),
      .reset         (reset),
      .job_valid     (job_valid),
      .job           (job),
      .pick_mode     (pick_mode_ff),
      .active_pieces (active_pieces),
      .pop           (pop),
      .clearing      (clearing),
      .rsp           (rsp)
   );

   assign rsp_valid        = rsp.valid;
   assign rsp_found        = rsp.found;
   assign rsp_picked_piece = rsp.picked;
   assign rsp_peer_count   = rsp.count;
   assign rsp_held         = rsp.held;
endmodule
`default_nettype wire

// ----- src/prp_ram.sv -----
`default_nettype none
module prp_ram #(
   parameter int WIDTH = 18,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ----- src/prp_front.sv -----
`default_nettype none
module prp_front (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   input  wire logic                            hold,
   input  wire logic [prp_pkg::CMD_BITS-1:0]    cmd,
   input  wire logic [prp_pkg::PIECE_BITS-1:0]  piece_id,
   input  wire logic [prp_pkg::WORD_IDX_BITS-1:0] word_index,
   input  wire logic [prp_pkg::AVAIL_WORD_BITS-1:0] word_data,
   input  wire logic [prp_pkg::NUM_BITS-1:0]    active_pieces,
   input  wire logic                            pop,
   output logic                                 busy,
   output logic                                 job_valid,
   output prp_pkg::job_type                     job
);
   import prp_pkg::*;

   job_type    q_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] fill_ff, fill_in;
   job_type    new_job;
   logic       push;

   // classify the command and check the piece range
   always_comb begin
      new_job       = '0;
      new_job.op    = (cmd <= CMD_BITS'(CMD_QUERY)) ? cmd_type'(cmd) : CMD_NOP;
      new_job.ok    = {1'b0, piece_id} < active_pieces;
      new_job.piece = piece_id;
      new_job.widx  = word_index;
      new_job.wdata = word_data;
   end

   assign busy      = hold || (fill_ff == 2'd2);
   assign push      = start && !busy;
   assign job_valid = (fill_ff != 2'd0);
   assign job       = q_ff[rd_ptr_ff];

   always_comb begin
      fill_in = fill_ff;
      if (push && !pop) fill_in = fill_ff + 2'd1;
      else if (!push && pop) fill_in = fill_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         fill_ff <= fill_in;
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop) rd_ptr_ff <= !rd_ptr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (push) q_ff[wr_ptr_ff] <= new_job;
   end
endmodule
`default_nettype wire

// ----- src/prp_back.sv -----
`default_nettype none
module prp_back (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         job_valid,
   input  wire prp_pkg::job_type             job,
   input  wire logic                         pick_mode,
   input  wire logic [prp_pkg::NUM_BITS-1:0] active_pieces,
   output logic                              pop,
   output logic                              clearing,
   output prp_pkg::rsp_type                  rsp
);
   import prp_pkg::*;

   typedef enum logic [3:0] {
      ST_CLEAR  = 4'b0001,
      ST_IDLE   = 4'b0010,
      ST_SINGLE = 4'b0100,
      ST_SCAN   = 4'b1000
   } state_type;

   state_type                  state_ff, state_in;
   job_type                    op_ff, op_in;
   logic [PIECE_BITS-1:0]      idx_ff, idx_in;
   logic                       best_valid_ff, best_valid_in;
   logic [PIECE_BITS-1:0]      best_ff, best_in;
   logic [COUNT_BITS-1:0]      best_cnt_ff, best_cnt_in;
   logic                       hit_ff, hit_in;
   logic [AVAIL_WORD_BITS-1:0] avail_ff [NUM_WORDS];
   logic [AVAIL_WORD_BITS-1:0] avail_in [NUM_WORDS];
   rsp_type                    rsp_ff, rsp_in;

   logic                  wr_en;
   logic [PIECE_BITS-1:0] wr_addr, rd_addr;
   entry_type             wr_data, rd_entry, ne;
   logic                  av, last, cand;

   prp_ram #(.WIDTH($bits(entry_type)), .DEPTH(MAX_PIECES)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_entry)
   );

   assign clearing = (state_ff == ST_CLEAR);
   assign rsp      = rsp_ff;
   assign av   = avail_ff[idx_ff[PIECE_BITS-1:BIT_IDX_BITS]][idx_ff[BIT_IDX_BITS-1:0]];
   assign last = (NUM_BITS'({1'b0, idx_ff}) + NUM_BITS'(1)) >= active_pieces;
   assign cand = !rd_entry.have && !rd_entry.rsv && av;

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      idx_in        = idx_ff;
      best_valid_in = best_valid_ff;
      best_in       = best_ff;
      best_cnt_in   = best_cnt_ff;
      hit_in        = hit_ff;
      avail_in      = avail_ff;
      rsp_in        = '0;
      pop           = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = idx_ff;
      wr_data       = '0;
      rd_addr       = '0;
      ne            = rd_entry;
      case (state_ff)
         ST_CLEAR: begin
            wr_en  = 1'b1;
            idx_in = idx_ff + PIECE_BITS'(1);
            if (idx_ff == '1) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (job_valid) begin
               pop   = 1'b1;
               op_in = job;
               case (job.op)
                  CMD_LOAD: begin
                     avail_in[job.widx] = job.wdata;
                     rsp_in.valid       = 1'b1;
                  end
                  CMD_ADD, CMD_REMOVE, CMD_PICK, CMD_INTEREST: begin
                     idx_in        = '0;
                     best_valid_in = 1'b0;
                     hit_in        = 1'b0;
                     if (active_pieces == '0) rsp_in.valid = 1'b1;
                     else state_in = ST_SCAN;
                  end
                  CMD_NOP: rsp_in.valid = 1'b1;
                  default: begin
                     rd_addr  = job.piece;
                     state_in = ST_SINGLE;
                  end
               endcase
            end
         end
         ST_SINGLE: begin
            rsp_in.valid = 1'b1;
            state_in     = ST_IDLE;
            wr_addr      = op_ff.piece;
            if (op_ff.ok) begin
               case (op_ff.op)
                  CMD_INC: begin
                     if (!rd_entry.have && rd_entry.cnt != COUNT_MAX)
                        ne.cnt = rd_entry.cnt + COUNT_BITS'(1);
                     wr_en = 1'b1;
                  end
                  CMD_DEC: begin
                     if (!rd_entry.have && rd_entry.cnt != '0)
                        ne.cnt = rd_entry.cnt - COUNT_BITS'(1);
                     wr_en = 1'b1;
                  end
                  CMD_RESERVE: begin
                     if (!rd_entry.have) ne.rsv = 1'b1;
                     wr_en = 1'b1;
                  end
                  CMD_UNRESERVE: begin
                     if (!rd_entry.have) ne.rsv = 1'b0;
                     wr_en = 1'b1;
                  end
                  CMD_GOT: begin
                     if (!rd_entry.have) ne = '{have: 1'b1, rsv: 1'b0, cnt: '0};
                     wr_en = 1'b1;
                  end
                  CMD_LOST: begin
                     if (rd_entry.have) ne = '0;
                     wr_en = 1'b1;
                  end
                  CMD_QUERY: begin
                     rsp_in.held  = rd_entry.have;
                     rsp_in.count = rd_entry.have ? '0 : rd_entry.cnt;
                  end
                  default: ;
               endcase
            end
            wr_data = ne;
         end
         ST_SCAN: begin
            case (op_ff.op)
               CMD_ADD: begin
                  if (av && !rd_entry.have && rd_entry.cnt != COUNT_MAX) begin
                     ne.cnt = rd_entry.cnt + COUNT_BITS'(1);
                     wr_en  = 1'b1;
                  end
               end
               CMD_REMOVE: begin
                  if (av && !rd_entry.have && rd_entry.cnt != '0) begin
                     ne.cnt = rd_entry.cnt - COUNT_BITS'(1);
                     wr_en  = 1'b1;
                  end
               end
               CMD_INTEREST: hit_in = hit_ff || (!rd_entry.have && av);
               CMD_PICK: begin
                  if (cand && (!best_valid_ff
                               || (pick_mode && rd_entry.cnt < best_cnt_ff))) begin
                     best_valid_in = 1'b1;
                     best_in       = idx_ff;
                     best_cnt_in   = rd_entry.cnt;
                  end
               end
               default: ;
            endcase
            wr_data = ne;
            if (last) begin
               state_in     = ST_IDLE;
               rsp_in.valid = 1'b1;
               if (op_ff.op == CMD_PICK && best_valid_in) begin
                  rsp_in.found  = 1'b1;
                  rsp_in.picked = best_in;
                  wr_en         = 1'b1;
                  wr_addr       = best_in;
                  wr_data       = '{have: 1'b0, rsv: 1'b1, cnt: best_cnt_in};
               end
               if (op_ff.op == CMD_INTEREST) rsp_in.found = hit_in;
            end else begin
               idx_in  = idx_ff + PIECE_BITS'(1);
               rd_addr = idx_in;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (state_ff == ST_IDLE && job_valid && state_in == ST_SCAN) rd_addr = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         idx_ff        <= '0;
         best_valid_ff <= 1'b0;
         hit_ff        <= 1'b0;
         rsp_ff        <= '0;
         for (int i = 0; i < NUM_WORDS; i++) avail_ff[i] <= '0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         best_valid_ff <= best_valid_in;
         hit_ff        <= hit_in;
         rsp_ff        <= rsp_in;
         avail_ff      <= avail_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      best_ff     <= best_in;
      best_cnt_ff <= best_cnt_in;
   end
endmodule
`default_nettype wire

// ----- src/prp_checker.sv -----
`default_nettype none
module prp_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                start,
   input wire logic                                busy,
   input wire logic                                rsp_valid,
   input wire logic                                rsp_found,
   input wire logic [prp_pkg::PIECE_BITS-1:0]      rsp_picked_piece,
   input wire logic [prp_pkg::COUNT_BITS-1:0]      rsp_peer_count,
   input wire logic                                rsp_held
);
   import prp_pkg::*;

   // memory clear runs right after reset
   a_busy_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> busy) else $error("busy low right after reset");

   a_no_piece_when_missed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_picked_piece == '0)
      else $error("piece index without a found piece");

   a_held_zero_count: assert property (@(posedge clock) disable iff (reset)
      rsp_held |-> rsp_peer_count == '0) else $error("held piece with a count");

   a_held_not_found: assert property (@(posedge clock) disable iff (reset)
      !(rsp_held && rsp_found)) else $error("held and found together");

   a_quiet_when_idle: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !rsp_found && !rsp_held)
      else $error("result flags without a strobe");
endmodule

bind rarest_first_piece_picker prp_checker u_prp_checker (.*);
`default_nettype wire

// ----- test/testbench.sv -----
`timescale 1ns / 100ps

import prp_pkg::*;

class piece_board;
   typedef struct {
      bit        found;
      bit [9:0]  picked;
      bit [15:0] count;
      bit        held;
   } answer_t;

   bit        have_bits[1024];
   bit        rsv_bits[1024];
   bit [15:0] peers[1024];
   bit [31:0] avail[32];
   bit        rarest;
   bit [10:0] piece_total;
   answer_t   answers[$];
   int        mismatches;
   int        checked;

   function new();
      rarest = 1'b1;
      piece_total = 11'd1024;
   endfunction

   function int tracked();
      return (piece_total > 11'd1024) ? 1024 : int'(piece_total);
   endfunction

   function void set_reg(bit idx, bit [10:0] v);
      if (idx == 1'b0) rarest = v[0];
      else piece_total = v;
   endfunction

   function bit offered(int p);
      return avail[p >> 5][p % 32];
   endfunction

   function void step_count(int p, bit up);
      if (!have_bits[p]) begin
         if (up && peers[p] != 16'hFFFF) peers[p]++;
         else if (!up && peers[p] != 0) peers[p]--;
      end
   endfunction

   // predict the answer of one accepted command and update the tracking state
   function void note_item(bit [3:0] c, bit [9:0] pid, bit [4:0] widx, bit [31:0] wdata);
      answer_t a;
      int      n;
      bit      ok;
      bit      got_one;
      int      best;
      a = '{default: 0};
      n = tracked();
      ok = (int'(pid) < n);
      case (c)
         CMD_LOAD: avail[widx] = wdata;
         CMD_ADD, CMD_REMOVE: begin
            for (int p = 0; p < n; p++)
               if (offered(p)) step_count(p, c == CMD_ADD);
         end
         CMD_INC: if (ok) step_count(pid, 1'b1);
         CMD_DEC: if (ok) step_count(pid, 1'b0);
         CMD_RESERVE: if (ok && !have_bits[pid]) rsv_bits[pid] = 1'b1;
         CMD_UNRESERVE: if (ok && !have_bits[pid]) rsv_bits[pid] = 1'b0;
         CMD_GOT, CMD_LOST: begin
            if (ok && (have_bits[pid] == (c == CMD_LOST))) begin
               have_bits[pid] = (c == CMD_GOT);
               rsv_bits[pid] = 1'b0;
               peers[pid] = '0;
            end
         end
         CMD_PICK: begin
            got_one = 1'b0;
            best = 0;
            for (int p = 0; p < n; p++) begin
               if (have_bits[p] || rsv_bits[p] || !offered(p)) continue;
               if (!got_one) begin
                  got_one = 1'b1;
                  best = p;
                  if (!rarest) break;
               end else if (peers[p] < peers[best]) begin
                  best = p;
               end
            end
            if (got_one) begin
               rsv_bits[best] = 1'b1;
               a.found = 1'b1;
               a.picked = 10'(best);
            end
         end
         CMD_INTEREST: begin
            for (int p = 0; p < n; p++)
               if (!have_bits[p] && offered(p)) begin
                  a.found = 1'b1;
                  break;
               end
         end
         CMD_QUERY: if (ok) begin
            a.held = have_bits[pid];
            a.count = have_bits[pid] ? 16'd0 : peers[pid];
         end
         default: ;
      endcase
      answers.push_back(a);
   endfunction

   function void check_result(bit f, bit [9:0] pk, bit [15:0] cnt, bit h);
      answer_t a;
      checked++;
      if (answers.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected result: found %0d piece %0d", f, pk);
         return;
      end
      a = answers.pop_front();
      if (a.found != f || a.picked != pk || a.count != cnt || a.held != h) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch: exp found %0d piece %0d count %0d held %0d, got %0d %0d %0d %0d",
                     a.found, a.picked, a.count, a.held, f, pk, cnt, h);
      end
   endfunction
endclass

module testbench;
   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [3:0]  req_cmd;
   logic [9:0]  req_piece_id;
   logic [4:0]  req_word_index;
   logic [31:0] req_word_data;
   logic        rsp_valid;
   logic        rsp_found;
   logic [9:0]  rsp_picked_piece;
   logic [15:0] rsp_peer_count;
   logic        rsp_held;
   logic        csr_write_enable;
   logic        csr_index;
   logic [10:0] csr_write_data;

   piece_board board;
   int         items_sent;
   int         idle_cycles;
   bit         no_gaps;

   rarest_first_piece_picker dut (.*);

   // 8 ns clock
   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   // result monitor: results cannot be stalled, so every strobe is checked
   always @(posedge clock) begin
      if (!reset && rsp_valid)
         board.check_result(rsp_found, rsp_picked_piece, rsp_peer_count, rsp_held);
   end

   // watchdog on cycles with no item or result moving; covers the reset
   // sweep and a full 1024-piece scan with plenty of margin
   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
         $display("watchdog expired");
         $display("DONE: errors detected");
         $finish;
      end
   end

   // one item; a random gap before it unless this phase runs back to back
   task automatic send_item(bit [3:0] c, bit [9:0] pid, bit [4:0] widx, bit [31:0] wdata);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_cmd <= c;
      req_piece_id <= pid;
      req_word_index <= widx;
      req_word_data <= wdata;
      do @(posedge clock); while (busy);
      board.note_item(c, pid, widx, wdata);
      items_sent++;
   endtask

   // let every pending result come back, then settle
   task automatic drain();
      start <= 1'b0;
      while (board.answers.size() > 0) @(posedge clock);
      repeat (6) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // both registers written back to back while idle
   task automatic write_regs(bit mode, bit [10:0] npieces);
      csr_write_enable <= 1'b1;
      csr_index <= 1'b0;
      csr_write_data <= {10'($urandom_range(0, 1023)), mode};
      @(posedge clock);
      board.set_reg(1'b0, {10'd0, mode});
      csr_index <= 1'b1;
      csr_write_data <= npieces;
      @(posedge clock);
      board.set_reg(1'b1, npieces);
      csr_write_enable <= 1'b0;
   endtask

   // mostly sensible commands on tracked pieces, some noise
   task automatic random_item();
      int        r;
      int        n;
      bit [3:0]  c;
      bit [9:0]  pid;
      bit [4:0]  widx;
      bit [31:0] wdata;
      n = board.tracked();
      r = $urandom_range(0, 99);
      if (r < 8) c = CMD_LOAD;
      else if (r < 14) c = CMD_ADD;
      else if (r < 18) c = CMD_REMOVE;
      else if (r < 32) c = CMD_INC;
      else if (r < 38) c = CMD_DEC;
      else if (r < 46) c = CMD_RESERVE;
      else if (r < 52) c = CMD_UNRESERVE;
      else if (r < 60) c = CMD_GOT;
      else if (r < 66) c = CMD_LOST;
      else if (r < 80) c = CMD_PICK;
      else if (r < 86) c = CMD_INTEREST;
      else if (r < 97) c = CMD_QUERY;
      else c = 4'($urandom_range(12, 15));
      if (n == 0 || $urandom_range(0, 9) == 0) pid = 10'($urandom);
      else pid = 10'($urandom_range(0, n - 1));
      if (n == 0 || $urandom_range(0, 4) == 0) widx = 5'($urandom);
      else widx = 5'($urandom_range(0, (n - 1) / 32));
      r = $urandom_range(0, 5);
      if (r == 0) wdata = '1;
      else if (r < 3) wdata = $urandom & $urandom;
      else wdata = $urandom;
      send_item(c, pid, widx, wdata);
   endtask

   initial begin
      bit        phase_mode[10] = '{1, 0, 1, 0, 1, 1, 0, 1, 0, 1};
      bit [10:0] phase_size[10] = '{16, 16, 1, 0, 64, 1024, 2047, 100, 33, 8};
      int        count;
      board = new();
      items_sent = 0;
      no_gaps = 1'b0;
      reset <= 1'b1;
      start <= 1'b0;
      req_cmd <= '0;
      req_piece_id <= '0;
      req_word_index <= '0;
      req_word_data <= '0;
      csr_write_enable <= 1'b0;
      csr_index <= 1'b0;
      csr_write_data <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (busy) @(posedge clock);

      // directed: eight pieces, rarest first
      write_regs(1'b1, 11'd8);
      send_item(CMD_QUERY, 10'd0, 5'd0, 32'd0);
      send_item(CMD_PICK, 10'd0, 5'd0, 32'd0);          // nothing offered yet
      send_item(CMD_INTEREST, 10'd0, 5'd0, 32'd0);
      send_item(CMD_LOAD, 10'd0, 5'd0, 32'hFFFF_FFFF);
      send_item(CMD_LOAD, 10'd0, 5'd31, 32'hA5A5_A5A5); // last word, beyond tracked
      send_item(CMD_ADD, 10'd0, 5'd0, 32'd0);
      send_item(CMD_ADD, 10'd0, 5'd0, 32'd0);
      send_item(CMD_INC, 10'd3, 5'd0, 32'd0);
      send_item(CMD_DEC, 10'd5, 5'd0, 32'd0);
      send_item(CMD_DEC, 10'd5, 5'd0, 32'd0);
      send_item(CMD_DEC, 10'd5, 5'd0, 32'd0);           // count floor
      send_item(CMD_QUERY, 10'd3, 5'd0, 32'd0);
      send_item(CMD_PICK, 10'd0, 5'd0, 32'd0);          // rarest piece wins
      send_item(CMD_PICK, 10'd0, 5'd0, 32'd0);          // tie, lowest index
      send_item(CMD_GOT, 10'd1, 5'd0, 32'd0);
      send_item(CMD_INC, 10'd1, 5'd0, 32'd0);           // held piece ignored
      send_item(CMD_GOT, 10'd1, 5'd0, 32'd0);           // repeated got
      send_item(CMD_QUERY, 10'd1, 5'd0, 32'd0);
      send_item(CMD_LOST, 10'd1, 5'd0, 32'd0);
      send_item(CMD_LOST, 10'd1, 5'd0, 32'd0);          // repeated lost
      send_item(CMD_RESERVE, 10'd2, 5'd0, 32'd0);
      send_item(CMD_UNRESERVE, 10'd0, 5'd0, 32'd0);
      send_item(CMD_QUERY, 10'd1023, 5'd0, 32'd0);      // out of range piece
      send_item(CMD_REMOVE, 10'd0, 5'd0, 32'd0);
      send_item(4'd15, 10'd0, 5'd0, 32'd0);             // unused command
      drain();

      // random phases over several settings; big sizes get few items
      foreach (phase_size[i]) begin
         write_regs(phase_mode[i], phase_size[i]);
         no_gaps = ($urandom_range(0, 3) == 0);
         count = (phase_size[i] >= 512) ? 25 : 65;
         repeat (count) random_item();
         drain();
      end

      repeat (20) @(posedge clock);
      if (board.answers.size() > 0) begin
         board.mismatches++;
         $display("%0d results never arrived", board.answers.size());
      end
      $display("covered %0d items and %0d results over 11 settings of mode and piece count",
               items_sent, board.checked);
      $display("mismatches: %0d", board.mismatches);
      if (board.mismatches == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule
